>>> src/mm_pkg.sv
`default_nettype none

package mm_pkg;

    localparam int MAX_DIM   = 8;
    localparam int FRAC_BITS = 16;

    localparam int ELEM_W    = 32;
    localparam int DIM_W     = 4;
    localparam int POS_W     = 3;
    localparam int CFG_IDX_W = 2;
    localparam int IDX_W     = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
    localparam int ADDR_W    = $clog2(MAX_DIM * MAX_DIM);
    // full-width sum of up to MAX_DIM exact products, plus sign
    localparam int ACC_W     = 2 * ELEM_W + $clog2(MAX_DIM) + 1;

    typedef enum logic [1:0] {
        REQ_LOAD_A  = 2'd0,
        REQ_LOAD_B  = 2'd1,
        REQ_COMPUTE = 2'd2
    } t_req;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_A_ROWS    = 2'd0,
        CFG_INNER_DIM = 2'd1,
        CFG_B_COLS    = 2'd2
    } t_cfg_reg;

    typedef enum logic {
        SEQ_IDLE,
        SEQ_RUN
    } t_seq_state;

    typedef struct packed {
        logic             first;
        logic             lastk;
        logic             lastel;
        logic [IDX_W-1:0] row;
        logic [IDX_W-1:0] col;
    } t_tag;

    // last usable index of a dimension: zero acts as one, large values as MAX_DIM
    function automatic logic [IDX_W-1:0] dim_last(input logic [DIM_W-1:0] d);
        logic [IDX_W-1:0] res;
        if (d == '0) begin
            res = '0;
        end else if (int'(d) > MAX_DIM) begin
            res = IDX_W'(MAX_DIM - 1);
        end else begin
            res = IDX_W'(d - DIM_W'(1));
        end
        return res;
    endfunction

endpackage

`default_nettype wire

>>> src/matrix_multiply.sv
`default_nettype none

// channel   direction  handshake                 payload
// input     in         i_valid / o_ready         i_req_type i_row_index i_col_index i_elem_value
// result    out        o_valid / i_ready         o_out_row o_out_col o_out_value o_saturated o_last
// config    in         i_cfg_valid / o_cfg_ready i_cfg_index i_cfg_data
//
// A compute issues one multiply-accumulate per cycle, unless a stalled result holds it, on
// the shared multiplier and accumulator until every term is done; o_ready is low for that
// time. A result shows on o_valid once the last term of its dot product has passed the
// operand, product, accumulator and result registers.
// Reset clears control state and sets every dimension to 8; the stores are not cleared.
// A stalled result freezes the whole pipeline, issue included.
module matrix_multiply (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_valid,
    output logic                                o_ready,
    input  wire logic [1:0]                     i_req_type,
    input  wire logic [mm_pkg::POS_W-1:0]       i_row_index,
    input  wire logic [mm_pkg::POS_W-1:0]       i_col_index,
    input  wire logic signed [mm_pkg::ELEM_W-1:0] i_elem_value,
    output logic                                o_valid,
    input  wire logic                           i_ready,
    output logic [mm_pkg::POS_W-1:0]            o_out_row,
    output logic [mm_pkg::POS_W-1:0]            o_out_col,
    output logic signed [mm_pkg::ELEM_W-1:0]    o_out_value,
    output logic                                o_saturated,
    output logic                                o_last,
    input  wire logic                           i_cfg_valid,
    output logic                                o_cfg_ready,
    input  wire logic [mm_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [mm_pkg::DIM_W-1:0]       i_cfg_data
);
    import mm_pkg::*;

    t_seq_state         r_state;
    t_seq_state         n_state;

    logic [DIM_W-1:0]   r_a_rows;
    logic [DIM_W-1:0]   r_inner_dim;
    logic [DIM_W-1:0]   r_b_cols;

    logic [IDX_W-1:0]   r_nr_m1;
    logic [IDX_W-1:0]   r_nk_m1;
    logic [IDX_W-1:0]   r_nc_m1;
    logic [IDX_W-1:0]   r_i;
    logic [IDX_W-1:0]   r_j;
    logic [IDX_W-1:0]   r_p;

    logic [ELEM_W-1:0]  r_a_mem [MAX_DIM*MAX_DIM];
    logic [ELEM_W-1:0]  r_b_mem [MAX_DIM*MAX_DIM];
    logic [ELEM_W-1:0]  r_a_q;
    logic [ELEM_W-1:0]  r_b_q;
    logic               r_s1_vld;
    t_tag               r_s1_tag;

    logic               w_in_acc;
    logic               w_start;
    logic               w_issue;
    logic               w_en;
    logic               w_last_issue;
    logic               w_in_range;
    logic               w_load_a;
    logic               w_load_b;
    logic [ADDR_W-1:0]  w_wr_addr;
    logic [ADDR_W-1:0]  w_a_addr;
    logic [ADDR_W-1:0]  w_b_addr;
    t_tag               w_tag;

    logic               w_mac_done;
    t_tag               w_mac_tag;
    logic [ELEM_W-1:0]  w_mac_value;
    logic               w_mac_sat;

    // pipeline advances whenever the result register is free or being emptied
    assign w_en     = !o_valid || i_ready;
    assign w_in_acc = i_valid && o_ready;
    assign w_start  = w_in_acc && (i_req_type == REQ_COMPUTE);

    // configuration
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_rows    <= DIM_W'(8);
            r_inner_dim <= DIM_W'(8);
            r_b_cols    <= DIM_W'(8);
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_A_ROWS:    r_a_rows    <= i_cfg_data;
                CFG_INNER_DIM: r_inner_dim <= i_cfg_data;
                CFG_B_COLS:    r_b_cols    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // sequencer
    always_comb begin
        n_state = r_state;
        case (r_state)
            SEQ_IDLE: if (w_start) n_state = SEQ_RUN;
            SEQ_RUN:  if (w_en && w_last_issue) n_state = SEQ_IDLE;
            default:  n_state = SEQ_IDLE;
        endcase
    end

    always_comb begin
        o_ready = 1'b0;
        w_issue = 1'b0;
        case (r_state)
            SEQ_IDLE: o_ready = 1'b1;
            SEQ_RUN:  w_issue = 1'b1;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= SEQ_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        w_tag.first  = (r_p == '0);
        w_tag.lastk  = (r_p == r_nk_m1);
        w_tag.lastel = (r_i == r_nr_m1) && (r_j == r_nc_m1);
        w_tag.row    = r_i;
        w_tag.col    = r_j;
        w_last_issue = w_tag.lastel && w_tag.lastk;
        w_a_addr     = ADDR_W'(int'(r_i) * MAX_DIM + int'(r_p));
        w_b_addr     = ADDR_W'(int'(r_p) * MAX_DIM + int'(r_j));
    end

    always_ff @(posedge i_clk) begin
        if (w_start) begin
            r_nr_m1 <= dim_last(r_a_rows);
            r_nk_m1 <= dim_last(r_inner_dim);
            r_nc_m1 <= dim_last(r_b_cols);
            r_i     <= '0;
            r_j     <= '0;
            r_p     <= '0;
        end else if (w_issue && w_en) begin
            // advance inner index, then column, then row
            if (r_p == r_nk_m1) begin
                r_p <= '0;
                if (r_j == r_nc_m1) begin
                    r_j <= '0;
                    r_i <= r_i + IDX_W'(1);
                end else begin
                    r_j <= r_j + IDX_W'(1);
                end
            end else begin
                r_p <= r_p + IDX_W'(1);
            end
        end
    end

    // stores
    assign w_in_range = (int'(i_row_index) < MAX_DIM) && (int'(i_col_index) < MAX_DIM);
    assign w_wr_addr  = ADDR_W'(int'(i_row_index) * MAX_DIM + int'(i_col_index));
    assign w_load_a   = w_in_acc && (i_req_type == REQ_LOAD_A) && w_in_range;
    assign w_load_b   = w_in_acc && (i_req_type == REQ_LOAD_B) && w_in_range;

    always_ff @(posedge i_clk) begin
        if (w_load_a) begin
            r_a_mem[w_wr_addr] <= i_elem_value;
        end
        if (w_en) begin
            r_a_q <= r_a_mem[w_a_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load_b) begin
            r_b_mem[w_wr_addr] <= i_elem_value;
        end
        if (w_en) begin
            r_b_q <= r_b_mem[w_b_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (w_en) begin
            r_s1_vld <= w_issue;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s1_tag <= w_tag;
        end
    end

    mm_mac u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (r_s1_vld),
        .i_tag   (r_s1_tag),
        .i_a     (r_a_q),
        .i_b     (r_b_q),
        .o_done  (w_mac_done),
        .o_tag   (w_mac_tag),
        .o_value (w_mac_value),
        .o_sat   (w_mac_sat)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (w_en) begin
            o_valid <= w_mac_done;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en && w_mac_done) begin
            o_out_row   <= POS_W'(w_mac_tag.row);
            o_out_col   <= POS_W'(w_mac_tag.col);
            o_out_value <= w_mac_value;
            o_saturated <= w_mac_sat;
            o_last      <= w_mac_tag.lastel;
        end
    end

`ifndef SYNTH
    a_idx_bounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == SEQ_RUN) |-> (r_i <= r_nr_m1) && (r_j <= r_nc_m1) && (r_p <= r_nk_m1))
        else $error("issue index beyond configured dimension");

    a_start_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_start |=> (r_i == '0) && (r_j == '0) && (r_p == '0) && (r_state == SEQ_RUN))
        else $error("compute did not start at element zero");

    a_sat_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_saturated) |->
            (o_out_value == $signed({1'b0, {(ELEM_W-1){1'b1}}}) ||
             o_out_value == $signed({1'b1, {(ELEM_W-1){1'b0}}})))
        else $error("clipped word not at a range limit");

    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_issue && w_en && w_last_issue) |=> o_ready)
        else $error("sequencer still busy after final issue");
`endif

endmodule

`default_nettype wire

>>> src/mm_mac.sv
`default_nettype none

module mm_mac (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_en,
    input  wire logic                       i_vld,
    input  wire mm_pkg::t_tag               i_tag,
    input  wire logic [mm_pkg::ELEM_W-1:0]  i_a,
    input  wire logic [mm_pkg::ELEM_W-1:0]  i_b,
    output logic                            o_done,
    output mm_pkg::t_tag                    o_tag,
    output logic [mm_pkg::ELEM_W-1:0]       o_value,
    output logic                            o_sat
);
    import mm_pkg::*;

    logic                       r_s2_vld;
    t_tag                       r_s2_tag;
    logic signed [2*ELEM_W-1:0] r_prod;
    logic signed [ACC_W-1:0]    r_acc;
    t_tag                       r_acc_tag;
    logic                       r_done;

    logic signed [ACC_W-1:0]    w_sh;
    logic                       w_fit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_vld <= 1'b0;
            r_done   <= 1'b0;
        end else if (i_en) begin
            r_s2_vld <= i_vld;
            r_done   <= r_s2_vld && r_s2_tag.lastk;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod   <= $signed(i_a) * $signed(i_b);
            r_s2_tag <= i_tag;
            if (r_s2_vld) begin
                // restart the sum on the first term of each dot product
                r_acc     <= r_s2_tag.first ? ACC_W'(r_prod) : r_acc + ACC_W'(r_prod);
                r_acc_tag <= r_s2_tag;
            end
        end
    end

    // floor shift, then clip to the element range
    always_comb begin
        w_sh  = r_acc >>> FRAC_BITS;
        w_fit = (&w_sh[ACC_W-1:ELEM_W-1]) || !(|w_sh[ACC_W-1:ELEM_W-1]);
        if (w_fit) begin
            o_value = w_sh[ELEM_W-1:0];
        end else if (w_sh[ACC_W-1]) begin
            o_value = {1'b1, {(ELEM_W-1){1'b0}}};
        end else begin
            o_value = {1'b0, {(ELEM_W-1){1'b1}}};
        end
        o_sat = !w_fit;
    end

    assign o_done = r_done;
    assign o_tag  = r_acc_tag;

endmodule

`default_nettype wire
